[src/assert_macros.svh]
// Assertion macros shared by the stack and queue engine modules.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SQE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define SQE_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[src/sqe_pkg.sv]
// Shared types and codes for the stack and queue engine.
// No dependencies; every module and interface of the block imports this package.
package sqe_pkg;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    // Opcodes of an input beat.
    localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PALL = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_PTOP = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SWAP = 3'd4;

    // Status codes of a result beat.
    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_USAGE      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOP_EMPTY  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

    // Offset from the top slot used to form the memory address.
    typedef enum logic [1:0] {
        OFS_ZERO  = 2'd0,
        OFS_ONE   = 2'd1,
        OFS_WALK  = 2'd2,
        OFS_COUNT = 2'd3
    } t_ofs;

    // Source of the memory write data.
    typedef enum logic [1:0] {
        WSRC_PUSH  = 2'd0,
        WSRC_RDATA = 2'd1,
        WSRC_TEMP  = 2'd2
    } t_wsrc;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_in;
        logic                rd_en;
        logic                wr_en;
        t_wsrc               wr_src;
        t_ofs                ofs;
        logic                cap_temp;
        logic                push_commit;
        logic                pop_commit;
        logic                walk_inc;
        logic                out_load;
        logic                out_has;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                push_ok;
        logic                empty;
        logic                lt_two;
        logic                full;
        logic                walk_last;
        logic                out_free;
    } t_stat;

endpackage

[src/sqe_in_if.sv]
// Input channel of the stack and queue engine: valid, ready and one command beat.
// Depends on sqe_pkg for the field widths.
interface sqe_in_if
    import sqe_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic        [OPCODE_W-1:0] opcode;
    logic signed [VALUE_W-1:0]  push_value;
    logic                       push_value_ok;

    modport source (output valid, opcode, push_value, push_value_ok, input ready);
    modport sink   (input valid, opcode, push_value, push_value_ok, output ready);
endinterface

[src/sqe_out_if.sv]
// Output channel of the stack and queue engine: valid, ready and one result beat.
// Depends on sqe_pkg for the field widths.
interface sqe_out_if
    import sqe_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  value;
    logic                       has_value;
    logic        [STATUS_W-1:0] status;
    logic                       last;

    modport source (output valid, value, has_value, status, last, input ready);
    modport sink   (input valid, value, has_value, status, last, output ready);
endinterface

[src/sqe_datapath.sv]
// Datapath of the stack and queue engine: entry memory, pointers, walk counter
// and result register. Depends on sqe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqe_datapath
    import sqe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    input  logic        [OPCODE_W-1:0] i_opcode,
    input  logic signed [VALUE_W-1:0]  i_push_value,
    input  logic                       i_push_value_ok,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [VALUE_W-1:0]  o_value,
    output logic                       o_has_value,
    output logic        [STATUS_W-1:0] o_status,
    output logic                       o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    logic [VALUE_W-1:0] r_mem [DEPTH];

    logic                r_queue_mode;
    logic [AW-1:0]       r_top,   n_top;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_walk;
    logic [OPCODE_W-1:0] r_op;
    logic [VALUE_W-1:0]  r_val;
    logic                r_ok;
    logic [VALUE_W-1:0]  r_rdata;
    logic [VALUE_W-1:0]  r_temp;

    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;
    logic                r_out_has;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_last;

    logic [AW-1:0]      ofs_val;
    logic [AW:0]        slot_sum;
    logic [AW-1:0]      slot;
    logic [AW-1:0]      top_dec;
    logic [AW-1:0]      mem_addr;
    logic [VALUE_W-1:0] wr_data;
    logic               out_free;

    // Slot of entry k from the top: (top + k) mod DEPTH, one compare and subtract.
    always_comb begin
        case (i_cmd.ofs)
            OFS_ZERO:  ofs_val = '0;
            OFS_ONE:   ofs_val = AW'(1);
            OFS_WALK:  ofs_val = r_walk;
            OFS_COUNT: ofs_val = r_count[AW-1:0];
            default:   ofs_val = '0;
        endcase
        slot_sum = {1'b0, r_top} + {1'b0, ofs_val};
        if (slot_sum >= DEPTH_W) begin
            slot = AW'(slot_sum - DEPTH_W);
        end else begin
            slot = slot_sum[AW-1:0];
        end
        top_dec  = (r_top == '0) ? LAST_SLOT : r_top - AW'(1);
        mem_addr = (i_cmd.push_commit && !r_queue_mode) ? top_dec : slot;
        case (i_cmd.wr_src)
            WSRC_PUSH:  wr_data = r_val;
            WSRC_RDATA: wr_data = r_rdata;
            WSRC_TEMP:  wr_data = r_temp;
            default:    wr_data = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[mem_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        if (i_cmd.push_commit) begin
            n_count = r_count + CW'(1);
            if (!r_queue_mode) begin
                n_top = top_dec;
            end
        end else if (i_cmd.pop_commit) begin
            n_count = r_count - CW'(1);
            n_top   = slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_mode <= 1'b0;
            r_top        <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_queue_mode <= i_cfg_wr_data;
            end
            r_top   <= n_top;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_opcode;
            r_val  <= i_push_value;
            r_ok   <= i_push_value_ok;
            r_walk <= '0;
        end else if (i_cmd.walk_inc) begin
            r_walk <= r_walk + AW'(1);
        end
        if (i_cmd.cap_temp) begin
            r_temp <= r_rdata;
        end
    end

    // Result register: the next beat may be loaded in the cycle the current one leaves.
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value  <= i_cmd.out_has ? r_rdata : '0;
            r_out_has    <= i_cmd.out_has;
            r_out_status <= i_cmd.out_status;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_has_value = r_out_has;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    always_comb begin
        o_stat.opcode    = r_op;
        o_stat.push_ok   = r_ok;
        o_stat.empty     = (r_count == '0);
        o_stat.lt_two    = (r_count < CW'(2));
        o_stat.full      = (r_count == DEPTH_C);
        o_stat.walk_last = ((CW'(r_walk) + CW'(1)) == r_count);
        o_stat.out_free  = out_free;
    end

    `SQE_ASSERT(a_count_range, r_count <= DEPTH_C, "entry count beyond depth")
    `SQE_ASSERT_IMPLY(a_push_room, i_cmd.push_commit, r_count != DEPTH_C, "push into full store")
    `SQE_ASSERT_IMPLY(a_pop_live, i_cmd.pop_commit, r_count != '0, "pop from empty store")

endmodule

[src/sqe_ctrl.sv]
// Controller of the stack and queue engine: one-hot state machine that sequences
// each command through the datapath. Depends on sqe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqe_ctrl
    import sqe_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_DECODE  = 8'b0000_0010,
        S_TOP_OUT = 8'b0000_0100,
        S_PA_OUT  = 8'b0000_1000,
        S_PA_RD   = 8'b0001_0000,
        S_SWAP_RB = 8'b0010_0000,
        S_SWAP_WA = 8'b0100_0000,
        S_SWAP_WB = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   swap_busy;

    assign o_in_ready = (r_state == S_IDLE);
    assign swap_busy  = (r_state == S_SWAP_RB) || (r_state == S_SWAP_WA);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.opcode)
                    OP_PUSH: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            n_state        = S_IDLE;
                            if (!i_stat.push_ok) begin
                                o_cmd.out_status = ST_USAGE;
                            end else if (i_stat.full) begin
                                o_cmd.out_status = ST_FULL;
                            end else begin
                                o_cmd.out_status  = ST_OK;
                                o_cmd.wr_en       = 1'b1;
                                o_cmd.wr_src      = WSRC_PUSH;
                                o_cmd.ofs         = OFS_COUNT;
                                o_cmd.push_commit = 1'b1;
                            end
                        end
                    end
                    OP_POP: begin
                        if (i_stat.out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            n_state        = S_IDLE;
                            if (i_stat.empty) begin
                                o_cmd.out_status = ST_POP_EMPTY;
                            end else begin
                                o_cmd.out_status = ST_OK;
                                o_cmd.ofs        = OFS_ONE;
                                o_cmd.pop_commit = 1'b1;
                            end
                        end
                    end
                    OP_PTOP: begin
                        if (!i_stat.empty) begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.ofs   = OFS_ZERO;
                            n_state     = S_TOP_OUT;
                        end else if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = ST_TOP_EMPTY;
                            n_state          = S_IDLE;
                        end
                    end
                    OP_PALL: begin
                        if (!i_stat.empty) begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.ofs   = OFS_WALK;
                            n_state     = S_PA_OUT;
                        end else if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = ST_OK;
                            n_state          = S_IDLE;
                        end
                    end
                    OP_SWAP: begin
                        if (!i_stat.lt_two) begin
                            o_cmd.rd_en = 1'b1;
                            o_cmd.ofs   = OFS_ZERO;
                            n_state     = S_SWAP_RB;
                        end else if (i_stat.out_free) begin
                            o_cmd.out_load   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = ST_SWAP_SHORT;
                            n_state          = S_IDLE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_TOP_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_has    = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            S_PA_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_has    = 1'b1;
                    o_cmd.out_last   = i_stat.walk_last;
                    o_cmd.out_status = ST_OK;
                    if (i_stat.walk_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.walk_inc = 1'b1;
                        n_state        = S_PA_RD;
                    end
                end
            end
            S_PA_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.ofs   = OFS_WALK;
                n_state     = S_PA_OUT;
            end
            S_SWAP_RB: begin
                o_cmd.cap_temp = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.ofs      = OFS_ONE;
                n_state        = S_SWAP_WA;
            end
            S_SWAP_WA: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.wr_src = WSRC_RDATA;
                o_cmd.ofs    = OFS_ZERO;
                n_state      = S_SWAP_WB;
            end
            S_SWAP_WB: begin
                if (i_stat.out_free) begin
                    o_cmd.wr_en      = 1'b1;
                    o_cmd.wr_src     = WSRC_TEMP;
                    o_cmd.ofs        = OFS_ONE;
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_last   = 1'b1;
                    o_cmd.out_status = ST_OK;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `SQE_ASSERT_IMPLY(a_load_free, o_cmd.out_load, i_stat.out_free, "result over held beat")
    `SQE_ASSERT_IMPLY(a_swap_two, swap_busy, !i_stat.lt_two, "swap with fewer than two entries")

endmodule

[src/stack_queue_engine.sv]
// Stack and queue engine: a bounded store of DEPTH signed 32-bit entries driven by
// command beats (push, print all, print top, pop, swap). A push adds on top, or at
// the bottom when the queue_mode register is set. Every valid command gives at least
// one result beat, the final one marked by last; errors give a status code and leave
// the store unchanged, and opcodes five to seven give nothing. One command is handled
// at a time through a single-port entry memory with a registered read, which sets the
// timing. Push, pop, every error and the unused opcodes are settled in the decode
// state, which loads the result beat, if any, into the result register; print top
// reads the top entry and then loads it, swap does two reads and two writes in turn,
// and print all reads and loads each entry in turn. A new command is accepted in the cycle
// after the previous one's last result is loaded, even if that beat is still waiting
// on the sink; a result beat that is ready to load waits in its state while the
// previous one still waits on the sink. No clearing pass is needed after reset. Write
// queue_mode only while the block is idle.
// Depends on sqe_pkg, sqe_in_if, sqe_out_if, sqe_ctrl and sqe_datapath.
module stack_queue_engine
    import sqe_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr_en,
    input  logic     i_cfg_wr_data,
    sqe_in_if.sink   i_cmd,
    sqe_out_if.source o_res
);

    // Commands and status travel between the controller and datapath as two structs.
    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_cmd.ready = in_ready;

    sqe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath latches the command beat when the controller accepts it and
    // owns the result register that drives the output channel.
    sqe_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_opcode        (i_cmd.opcode),
        .i_push_value    (i_cmd.push_value),
        .i_push_value_ok (i_cmd.push_value_ok),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_value         (o_res.value),
        .o_has_value     (o_res.has_value),
        .o_status        (o_res.status),
        .o_last          (o_res.last)
    );

endmodule
